[rtl/fts_pkg.sv]
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants for the Fenwick tree prefix-sum engine.
// ----------------------------------------------------------------------------
package fts_pkg;

  localparam int IDX_W       = 11;  // width of positions and of the size register
  localparam int WALK_W      = 12;  // an add walk may step one past the 11-bit range
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_PREFIX = 2'd1,
    OP_RANGE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_SUM,
    CMD_CLEAR,
    CMD_BAD
  } cmd_kind_t;

  // A sum walks 'first' with plus and then 'second' with minus; index zero
  // ends a walk at once. An add walks upward from 'first' while within 'limit'.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   first;
    logic [IDX_W-1:0]   second;
    logic [IDX_W-1:0]   limit;
    logic [DATA_W-1:0]  amount;
  } cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_CLEAR,
    S_RESULT
  } back_state_t;

endpackage

[rtl/fts_if.sv]
// ----------------------------------------------------------------------------
// fts_if
// Valid/ready channels of the Fenwick tree engine: request, response, config.
// ----------------------------------------------------------------------------
interface fts_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [10:0]        position;
  logic [10:0]        right_end;
  logic signed [31:0] amount;

  modport source (output valid, operation, position, right_end, amount, input ready);
  modport sink   (input valid, operation, position, right_end, amount, output ready);
endinterface

interface fts_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] total;
  logic               status;

  modport source (output valid, total, status, input ready);
  modport sink   (input valid, total, status, output ready);
endinterface

interface fts_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/fts_front.sv]
// ----------------------------------------------------------------------------
// fts_front
// Accepts request words, checks their indexes and turns them into commands.
// ----------------------------------------------------------------------------
module fts_front #(
  parameter int SIZE = 1024
) (
  fts_req_if.sink                   req,
  input  logic [fts_pkg::IDX_W-1:0] size_in_use,
  input  logic                      run_ok,
  output fts_pkg::cmd_t             cmd,
  output logic                      cmd_valid,
  input  logic                      cmd_ready
);
  import fts_pkg::*;

  localparam int unsigned IdxMax  = (1 << IDX_W) - 1;
  localparam int unsigned SizeCap = (SIZE > IdxMax) ? IdxMax : SIZE;

  logic [IDX_W-1:0] n;
  logic [IDX_W-1:0] left_below;

  assign n          = (size_in_use > IDX_W'(SizeCap)) ? IDX_W'(SizeCap) : size_in_use;
  assign left_below = (req.position != '0) ? req.position - IDX_W'(1) : '0;

  assign cmd_valid = req.valid && run_ok;
  assign req.ready = cmd_ready && run_ok;

  always_comb begin
    cmd.first  = req.position;
    cmd.second = '0;
    cmd.limit  = n;
    cmd.amount = req.amount;
    cmd.kind   = CMD_BAD;
    unique case (req.operation)
      OP_ADD: begin
        if (req.position != '0 && req.position <= n) cmd.kind = CMD_ADD;
      end
      OP_PREFIX: begin
        if (req.position <= n) cmd.kind = CMD_SUM;
      end
      OP_RANGE: begin
        cmd.first  = req.right_end;
        cmd.second = left_below;
        if (req.position <= n && req.right_end <= n) cmd.kind = CMD_SUM;
      end
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
      end
      default: begin
        cmd.kind = CMD_BAD;
      end
    endcase
  end

endmodule

[rtl/fts_queue.sv]
// ----------------------------------------------------------------------------
// fts_queue
// Short command queue between the front and the back of the engine.
// ----------------------------------------------------------------------------
module fts_queue (
  input  logic          clk,
  input  logic          rst,
  input  fts_pkg::cmd_t push_cmd,
  input  logic          push_valid,
  output logic          push_ready,
  output fts_pkg::cmd_t pop_cmd,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import fts_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CW'(1))
    else $error("queue count did not follow a push");

endmodule

[rtl/fts_back.sv]
// ----------------------------------------------------------------------------
// fts_back
// Walks the partial-sum memory for each command and registers the response.
// ----------------------------------------------------------------------------
module fts_back #(
  parameter int SIZE = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  fts_pkg::cmd_t q_cmd,
  input  logic          q_valid,
  output logic          q_ready,
  output logic          run_ok,
  fts_rsp_if.source     rsp
);
  import fts_pkg::*;

  localparam int AW = $clog2(SIZE);

  back_state_t       state;
  back_state_t       state_next;
  cmd_t              cur;
  logic [WALK_W-1:0] idx;
  logic [WALK_W-1:0] idx_low;
  logic [WALK_W-1:0] idx_step;
  logic              phase;
  logic [DATA_W-1:0] acc;
  logic              pend;
  logic              pend_sub;
  logic [AW-1:0]     pend_addr;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     sweep;
  logic              walk_live;
  logic              pop;
  logic              rd_issue;
  logic              start_second;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              load_out;
  logic              out_valid;
  logic [DATA_W-1:0] out_total;
  logic              out_status;

  logic [DATA_W-1:0] mem [SIZE];

  assign walk_live = (idx != '0) &&
                     ((cur.kind != CMD_ADD) || (idx <= {1'b0, cur.limit}));
  assign idx_low   = idx & (~idx + WALK_W'(1));
  assign idx_step  = (cur.kind == CMD_ADD) ? idx + idx_low : idx & (idx - WALK_W'(1));
  assign rd_addr   = AW'(idx - WALK_W'(1));

  assign q_ready    = pop;
  assign run_ok     = (state != S_INIT);
  assign rsp.valid  = out_valid;
  assign rsp.total  = out_total;
  assign rsp.status = out_status;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    rd_issue     = 1'b0;
    start_second = 1'b0;
    mem_we       = 1'b0;
    wr_addr      = pend_addr;
    wr_data      = rd_data + cur.amount;
    load_out     = 1'b0;
    unique case (state) inside
      S_INIT, S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = sweep;
        wr_data = '0;
        if (sweep == AW'(SIZE - 1)) state_next = (state == S_INIT) ? S_IDLE : S_RESULT;
      end
      S_IDLE: begin
        pop = q_valid;
        if (q_valid) begin
          unique case (q_cmd.kind)
            CMD_BAD:   state_next = S_RESULT;
            CMD_CLEAR: state_next = S_CLEAR;
            default:   state_next = S_WALK;
          endcase
        end
      end
      S_WALK: begin
        // Reads go out every cycle while the walk is live; each read word is used in the cycle after its read.
        mem_we = pend && (cur.kind == CMD_ADD);
        if (walk_live) begin
          rd_issue = 1'b1;
        end else if (cur.kind == CMD_SUM && !phase) begin
          start_second = 1'b1;
        end else if (!pend) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= q_cmd;
      idx   <= {1'b0, q_cmd.first};
      phase <= 1'b0;
      acc   <= '0;
    end else begin
      if (rd_issue) begin
        idx       <= idx_step;
        pend_addr <= rd_addr;
        pend_sub  <= phase;
      end
      if (start_second) begin
        idx   <= {1'b0, cur.second};
        phase <= 1'b1;
      end
      if (pend && cur.kind == CMD_SUM) begin
        acc <= pend_sub ? acc - rd_data : acc + rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      sweep <= '0;
    end else begin
      pend <= rd_issue;
      if (state == S_INIT || state == S_CLEAR) begin
        sweep <= (sweep == AW'(SIZE - 1)) ? '0 : sweep + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_total  <= acc;
      out_status <= (cur.kind == CMD_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst)           out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (rsp.ready) out_valid <= 1'b0;
  end

  a_read_pending: assert property (@(posedge clk) disable iff (rst)
    rd_issue |=> pend)
    else $error("issued read has no pending word");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && !out_valid) |=> out_valid)
    else $error("result not loaded into a free output register");

  a_acc_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && cur.kind == CMD_ADD) |-> acc == '0)
    else $error("accumulator disturbed during an add walk");

  a_walk_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT || state == S_IDLE) |-> !pend)
    else $error("read still pending after the walk ended");

endmodule

[rtl/fenwick_tree_prefix_sum.sv]
// ----------------------------------------------------------------------------
// fenwick_tree_prefix_sum
// Binary indexed tree engine: add, prefix sum, range sum and clear over a
// memory of 32-bit partial sums.
// ----------------------------------------------------------------------------
//  port  role  word
//  req   sink  operation, position, right_end, amount
//  rsp   src   total, status
//  cfg   sink  data (size_in_use)
//
// A walk takes one tree node per cycle, as the single memory read port reads
// one node at a time; a prefix sum or an add walks one index chain and a range
// sum walks two, where a chain holds at most 11 tree nodes.
// A clear writes one memory word per cycle over all SIZE words.
// After reset a sweep zeroes the memory; no request word is
// taken until it ends. Config writes are always taken.
// A two-word command queue lets requests come in while a response waits.
// ----------------------------------------------------------------------------
module fenwick_tree_prefix_sum #(
  parameter int SIZE = 1024
) (
  input  logic      clk,
  input  logic      rst,
  fts_req_if.sink   req,
  fts_rsp_if.source rsp,
  fts_cfg_if.sink   cfg
);
  import fts_pkg::*;

  logic [IDX_W-1:0] size_in_use;
  cmd_t             push_cmd;
  logic             push_valid;
  logic             push_ready;
  cmd_t             pop_cmd;
  logic             pop_valid;
  logic             pop_ready;
  logic             run_ok;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst)            size_in_use <= SIZE_RESET;
    else if (cfg.valid) size_in_use <= cfg.data;
  end

  fts_front #(.SIZE(SIZE)) u_front (
    .req         (req),
    .size_in_use (size_in_use),
    .run_ok      (run_ok),
    .cmd         (push_cmd),
    .cmd_valid   (push_valid),
    .cmd_ready   (push_ready)
  );

  fts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  fts_back #(.SIZE(SIZE)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_cmd   (pop_cmd),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .run_ok  (run_ok),
    .rsp     (rsp)
  );

endmodule
